>>> hw/rtl/ecbm_pkg.sv
// ----------------------------------------------------------------------------
// ecbm_pkg
// Shared constants and types for the banked EEPROM mailbox: command codes,
// status bits, bus access codes and the store control group.
// ----------------------------------------------------------------------------
package ecbm_pkg;

   localparam int BANK_COUNT_DEF = 8;
   localparam int BANK_BYTES_DEF = 256;

   // mailbox commands
   localparam logic [7:0] CMD_READ  = 8'h4E;
   localparam logic [7:0] CMD_WRITE = 8'h4D;
   localparam logic [7:0] CMD_BANK  = 8'h42;

   // status byte
   localparam logic [7:0] STATUS_OBF = 8'h01;
   localparam logic [7:0] STATUS_NONE = 8'h00;

   localparam logic [7:0] BANK_FIELD_MASK = 8'h07;

   // bus access codes
   localparam logic OP_READ   = 1'b0;
   localparam logic OP_WRITE  = 1'b1;
   localparam logic PORT_DATA = 1'b0;
   localparam logic PORT_CMD  = 1'b1;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

>>> hw/rtl/ecbm_store.sv
// ----------------------------------------------------------------------------
// ecbm_store
// Byte store for all banks: one registered read and, outside the clearing
// pass that fills every byte with 0xFF after reset, one write per cycle.
// ----------------------------------------------------------------------------
module ecbm_store #(
   parameter int DEPTH = ecbm_pkg::BANK_COUNT_DEF * ecbm_pkg::BANK_BYTES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ecbm_pkg::mem_ctl_type   mem_ctl,
   input  logic [AW-1:0]           mem_addr,
   input  logic [7:0]              mem_wdata,
   output logic [7:0]              mem_rdata,
   output logic                    clearing
);

   logic [7:0]    mem [DEPTH];
   logic          clr_active_ff;
   logic          clr_active_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic [7:0]    rdata_ff;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // erase sweep owns the write port until it is done
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= 8'hFF;
      end else if (mem_ctl.wr_en) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;
   assign clearing  = clr_active_ff;

endmodule

>>> hw/rtl/ecbm_ctrl.sv
// ----------------------------------------------------------------------------
// ecbm_ctrl
// Mailbox protocol engine: registers the bus access, runs the command
// sequence, drives the store and registers the read byte.
// ----------------------------------------------------------------------------
module ecbm_ctrl #(
   parameter int BANK_COUNT = ecbm_pkg::BANK_COUNT_DEF,
   parameter int BANK_BYTES = ecbm_pkg::BANK_BYTES_DEF,
   parameter int AW         = $clog2(BANK_COUNT * BANK_BYTES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  operation,
   input  logic                  port_select,
   input  logic [7:0]            write_byte,
   output ecbm_pkg::mem_ctl_type mem_ctl,
   output logic [AW-1:0]         mem_addr,
   output logic [7:0]            mem_wdata,
   input  logic [7:0]            mem_rdata,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_read_byte
);

   localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int OW = $clog2(BANK_BYTES);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RD_OFFSET,
      PH_WR_OFFSET,
      PH_WR_DATA,
      PH_BANK
   } phase_type;

   // reduction tables, fixed at elaboration
   logic [BW-1:0] bank_tab [8];
   logic [OW-1:0] off_tab [256];

   for (genvar g = 0; g < 8; g++) begin : g_bank_tab
      assign bank_tab[g] = BW'(g % BANK_COUNT);
   end
   for (genvar g = 0; g < 256; g++) begin : g_off_tab
      assign off_tab[g] = OW'(g % BANK_BYTES);
   end

   logic          s1_valid_ff;
   logic          s1_op_ff;
   logic          s1_port_ff;
   logic [7:0]    s1_byte_ff;

   phase_type     phase_ff,   phase_in;
   logic [BW-1:0] bank_ff,    bank_in;
   logic [OW-1:0] pend_ff,    pend_in;
   logic [7:0]    ob_ff,      ob_in;
   logic          obf_ff,     obf_in;
   logic          ob_mem_ff,  ob_mem_in;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;

   logic [7:0]    ob_cur;
   logic [2:0]    bank_field;
   logic [OW-1:0] off_sel;
   logic          rd_en;
   logic          wr_en;

   // a finished offset read lands in the store's read register in the next cycle
   assign ob_cur     = ob_mem_ff ? mem_rdata : ob_ff;
   assign bank_field = 3'(s1_byte_ff & ecbm_pkg::BANK_FIELD_MASK);

   always_comb begin
      phase_in    = phase_ff;
      bank_in     = bank_ff;
      pend_in     = pend_ff;
      ob_in       = ob_cur;
      obf_in      = obf_ff;
      rsp_byte_in = 8'h00;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      off_sel     = pend_ff;
      if (s1_valid_ff) begin
         if (s1_op_ff == ecbm_pkg::OP_WRITE) begin
            if (s1_port_ff == ecbm_pkg::PORT_CMD) begin
               priority if (s1_byte_ff == ecbm_pkg::CMD_READ) begin
                  phase_in = PH_RD_OFFSET;
               end else if (s1_byte_ff == ecbm_pkg::CMD_WRITE) begin
                  phase_in = PH_WR_OFFSET;
               end else if (s1_byte_ff == ecbm_pkg::CMD_BANK) begin
                  phase_in = PH_BANK;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else begin
               unique case (phase_ff)
                  PH_RD_OFFSET: begin
                     off_sel  = off_tab[s1_byte_ff];
                     rd_en    = 1'b1;
                     obf_in   = 1'b1;
                     phase_in = PH_IDLE;
                  end
                  PH_WR_OFFSET: begin
                     pend_in  = off_tab[s1_byte_ff];
                     phase_in = PH_WR_DATA;
                  end
                  PH_WR_DATA: begin
                     wr_en    = 1'b1;
                     phase_in = PH_IDLE;
                  end
                  PH_BANK: begin
                     bank_in  = bank_tab[bank_field];
                     phase_in = PH_IDLE;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end else if (s1_port_ff == ecbm_pkg::PORT_CMD) begin
            rsp_byte_in = obf_ff ? ecbm_pkg::STATUS_OBF : ecbm_pkg::STATUS_NONE;
         end else begin
            rsp_byte_in = ob_cur;
            obf_in      = 1'b0;
         end
      end
      ob_mem_in = rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= PH_IDLE;
         bank_ff      <= '0;
         pend_ff      <= '0;
         ob_ff        <= 8'h00;
         obf_ff       <= 1'b0;
         ob_mem_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         phase_ff     <= phase_in;
         bank_ff      <= bank_in;
         pend_ff      <= pend_in;
         ob_ff        <= ob_in;
         obf_ff       <= obf_in;
         ob_mem_ff    <= ob_mem_in;
         rsp_valid_ff <= s1_valid_ff;
      end
      s1_op_ff    <= operation;
      s1_port_ff  <= port_select;
      s1_byte_ff  <= write_byte;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign mem_ctl.rd_en  = rd_en;
   assign mem_ctl.wr_en  = wr_en;
   assign mem_addr       = AW'(bank_ff) * AW'(BANK_BYTES) + AW'(off_sel);
   assign mem_wdata      = s1_byte_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;

endmodule

>>> hw/rtl/ec_banked_eeprom_mailbox.sv
// Result: an accepted item passes the stage-1 register and the result
// register and shows for one cycle on rsp_valid and rsp_read_byte.
// Throughput: one item per cycle when not busy; the receiver cannot stall it.
// Reset: control state clears, then an erase sweep writes 0xFF to every byte
// of the store (BANK_COUNT * BANK_BYTES, 2048 by default), one byte a cycle
// through the store's single write port; busy stays high for the sweep.
// ----------------------------------------------------------------------------
// ec_banked_eeprom_mailbox
// Embedded-controller mailbox with data and command/status ports in front of
// a banked byte store.
// ----------------------------------------------------------------------------
module ec_banked_eeprom_mailbox #(
   parameter int BANK_COUNT = ecbm_pkg::BANK_COUNT_DEF,
   parameter int BANK_BYTES = ecbm_pkg::BANK_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic       req_port_select,
   input  logic [7:0] req_write_byte,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_byte
);

   localparam int DEPTH = BANK_COUNT * BANK_BYTES;
   localparam int AW    = $clog2(DEPTH);

   ecbm_pkg::mem_ctl_type mem_ctl;
   logic [AW-1:0]         mem_addr;
   logic [7:0]            mem_wdata;
   logic [7:0]            mem_rdata;
   logic                  clearing;

   assign busy = clearing;

   ecbm_ctrl #(
      .BANK_COUNT (BANK_COUNT),
      .BANK_BYTES (BANK_BYTES),
      .AW         (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (start && !clearing),
      .operation     (req_operation),
      .port_select   (req_port_select),
      .write_byte    (req_write_byte),
      .mem_ctl       (mem_ctl),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata),
      .mem_rdata     (mem_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_read_byte (rsp_read_byte)
   );

   ecbm_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata),
      .clearing  (clearing)
   );

endmodule

>>> hw/rtl/ecbm_checker.sv
// ----------------------------------------------------------------------------
// ecbm_checker
// Port-level checks on the mailbox: result timing, write and status result
// values, and busy during the erase sweep.
// ----------------------------------------------------------------------------
module ecbm_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_operation,
   input logic       req_port_select,
   input logic [7:0] req_write_byte,
   input logic       rsp_valid,
   input logic [7:0] rsp_read_byte
);

   logic accepted;
   assign accepted = start && !busy;

   // every accepted item gives its result on rsp_valid
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accepted |-> ##2 rsp_valid)
      else $error("accepted item gave no result");

   // no result without an item behind it
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accepted, 2))
      else $error("result without an accepted item");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (accepted && req_operation == ecbm_pkg::OP_WRITE) |-> ##2 (rsp_read_byte == 8'h00))
      else $error("write access returned a non-zero byte");

   a_status_bits: assert property (@(posedge clock) disable iff (reset)
      (accepted && req_operation == ecbm_pkg::OP_READ
       && req_port_select == ecbm_pkg::PORT_CMD) |-> ##2 (rsp_read_byte[7:1] == 7'd0))
      else $error("status read has stray bits set");

   // erase sweep holds the block off right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> busy)
      else $error("not busy after reset");

endmodule

bind ec_banked_eeprom_mailbox ecbm_checker u_checker (.*);
